// File: hw/rtl/tcp_segment_reorder_queue_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the segment reorder queue
// Checks are sampled on clk and are off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef TCP_SEGMENT_REORDER_QUEUE_UNIT_ASSERT_SVH
`define TCP_SEGMENT_REORDER_QUEUE_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define SRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define SRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/srq_pkg.sv
// ---------------------------------------------------------------------------
// srq_pkg
// Shared types, codes and sequence compare helpers for the reorder queue.
// ---------------------------------------------------------------------------
package srq_pkg;

  // Operation codes
  localparam logic [2:0] FN_INSERT  = 3'd0;
  localparam logic [2:0] FN_POP     = 3'd1;
  localparam logic [2:0] FN_PEEK    = 3'd2;
  localparam logic [2:0] FN_BAR_ADD = 3'd3;
  localparam logic [2:0] FN_BAR_REM = 3'd4;
  localparam logic [2:0] FN_CLEAR   = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DROP  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_BLOCK = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // Result kinds selected by the controller
  localparam logic [3:0] RK_OK    = 4'd0;
  localparam logic [3:0] RK_DROP  = 4'd1;
  localparam logic [3:0] RK_REPL  = 4'd2;
  localparam logic [3:0] RK_EMPTY = 4'd3;
  localparam logic [3:0] RK_BLOCK = 4'd4;
  localparam logic [3:0] RK_FULL  = 4'd5;
  localparam logic [3:0] RK_DONE  = 4'd6;
  localparam logic [3:0] RK_TAG   = 4'd7;
  localparam logic [3:0] RK_BAR   = 4'd8;

  // Read address selects
  localparam logic [2:0] RD_SCAN  = 3'd0;
  localparam logic [2:0] RD_NEXT  = 3'd1;
  localparam logic [2:0] RD_HEAD  = 3'd2;
  localparam logic [2:0] RD_SHIFT = 3'd3;
  localparam logic [2:0] RD_CLOSE = 3'd4;

  // Write selects
  localparam logic [1:0] WR_NEW   = 2'd0;
  localparam logic [1:0] WR_SHIFT = 2'd1;
  localparam logic [1:0] WR_CLOSE = 2'd2;
  localparam logic [1:0] WR_BAR   = 2'd3;

  // Insert decisions
  localparam logic [1:0] ACT_INS  = 2'd0;
  localparam logic [1:0] ACT_REPL = 2'd1;
  localparam logic [1:0] ACT_DROP = 2'd2;

  typedef struct packed {
    logic [31:0] st;
    logic [31:0] en;
    logic [15:0] tag;
    logic [7:0]  bar;
  } entry_t;

  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic [2:0] rd_sel;
    logic       scan_step;
    logic       cap_head;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       k_shift;
    logic       k_one;
    logic       k_dec;
    logic       k_inc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       res_load;
    logic [3:0] res_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       empty;
    logic       full;
    logic       brk;
    logic       idx_zero;
    logic [1:0] action;
    logic       pos_eq_cnt;
    logic       km1_eq_pos;
    logic       k_eq_cnt;
    logic       head_bar_zero;
    logic       out_free;
  } sts_t;

  // a before b, modulo 2^32
  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  // lo <= x <= hi, modulo 2^32
  function automatic logic seq_within(input logic [31:0] x, input logic [31:0] lo,
                                      input logic [31:0] hi);
    logic [31:0] span;
    logic [31:0] off;
    span = hi - lo;
    off  = x - lo;
    return span >= off;
  endfunction

endpackage

// File: hw/rtl/srq_ctrl.sv
// ---------------------------------------------------------------------------
// srq_ctrl
// Sequencer for insert scan, table shifts, head access and result hand-off.
// ---------------------------------------------------------------------------
module srq_ctrl
  import srq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  output logic in_rdy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SH_RD  = 4'd4;
  localparam logic [3:0] S_SH_WR  = 4'd5;
  localparam logic [3:0] S_WNEW   = 4'd6;
  localparam logic [3:0] S_HEAD   = 4'd7;
  localparam logic [3:0] S_CL_CHK = 4'd8;
  localparam logic [3:0] S_CL_WR  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [3:0] rk_r, rk_nxt;

  assign in_rdy = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    rk_nxt    = rk_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.func)
          FN_INSERT: begin
            if (sts.full) begin
              rk_nxt    = RK_FULL;
              state_nxt = S_DONE;
            end else if (sts.empty) begin
              state_nxt = S_WNEW;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_SCAN;
              state_nxt  = S_SCAN;
            end
          end
          FN_POP, FN_PEEK, FN_BAR_ADD, FN_BAR_REM: begin
            if (sts.empty) begin
              rk_nxt    = RK_EMPTY;
              state_nxt = S_DONE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_nxt  = S_HEAD;
            end
          end
          FN_CLEAR: begin
            cmd.cnt_clr = 1'b1;
            rk_nxt      = RK_DONE;
            state_nxt   = S_DONE;
          end
          default: begin
            rk_nxt    = RK_DONE;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.brk) begin
          state_nxt = S_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = S_DECIDE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_NEXT;
          end
        end
      end
      S_DECIDE: begin
        unique case (sts.action)
          ACT_DROP: begin
            rk_nxt    = RK_DROP;
            state_nxt = S_DONE;
          end
          ACT_REPL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_NEW;
            rk_nxt     = RK_REPL;
            state_nxt  = S_DONE;
          end
          default: begin
            cmd.k_shift = 1'b1;
            state_nxt   = sts.pos_eq_cnt ? S_WNEW : S_SH_RD;
          end
        endcase
      end
      S_SH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SHIFT;
        state_nxt  = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SHIFT;
        cmd.k_dec  = 1'b1;
        state_nxt  = sts.km1_eq_pos ? S_WNEW : S_SH_RD;
      end
      S_WNEW: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_NEW;
        cmd.cnt_inc = 1'b1;
        rk_nxt      = RK_OK;
        state_nxt   = S_DONE;
      end
      S_HEAD: begin
        if (sts.func == FN_BAR_ADD || sts.func == FN_BAR_REM) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_BAR;
          rk_nxt     = RK_BAR;
          state_nxt  = S_DONE;
        end else if (!sts.head_bar_zero) begin
          rk_nxt    = RK_BLOCK;
          state_nxt = S_DONE;
        end else begin
          cmd.cap_head = 1'b1;
          rk_nxt       = RK_TAG;
          if (sts.func == FN_POP) begin
            cmd.k_one = 1'b1;
            state_nxt = S_CL_CHK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CL_CHK: begin
        if (sts.k_eq_cnt) begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_CLOSE;
          state_nxt  = S_CL_WR;
        end
      end
      S_CL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_CLOSE;
        cmd.k_inc  = 1'b1;
        state_nxt  = S_CL_CHK;
      end
      S_DONE: begin
        cmd.res_kind = rk_r;
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rk_r    <= RK_DONE;
    end else begin
      state_r <= state_nxt;
      rk_r    <= rk_nxt;
    end
  end

endmodule

// File: hw/rtl/srq_dp.sv
// ---------------------------------------------------------------------------
// srq_dp
// Entry memory, scan and shift counters, insert decision and result register.
// ---------------------------------------------------------------------------
module srq_dp
  import srq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_func,
  input  logic [31:0] in_start,
  input  logic [31:0] in_end,
  input  logic [15:0] in_tag,
  input  logic        out_rdy,
  output logic        out_vld,
  output logic [49:0] out_fields
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  entry_t mem [CAPACITY];
  entry_t rd_q;

  logic [2:0]       func_r;
  logic [31:0]      s_r, e_r;
  logic [15:0]      t_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;
  logic             ineg_r, pvalid_r;
  entry_t           p_r;
  logic [CNT_W-1:0] k_r;
  logic [7:0]       bar_r;
  logic             out_vld_r;
  logic [49:0]      out_r;

  logic [CNT_W-1:0] k_m1;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           wr_data;
  logic [7:0]       bar_new;
  logic [1:0]       action;
  logic [2:0]       r_status;
  logic [15:0]      r_otag, r_ftag;
  logic             r_ov, r_fv;
  logic [7:0]       r_bar;

  assign k_m1 = k_r - CNT_W'(1);
  assign pos  = ineg_r ? '0 : idx_r + IDX_W'(1);

  // Read address select
  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN:  rd_addr = idx_r;
      RD_NEXT:  rd_addr = idx_r - IDX_W'(1);
      RD_SHIFT: rd_addr = k_m1[IDX_W-1:0];
      RD_CLOSE: rd_addr = k_r[IDX_W-1:0];
      default:  rd_addr = '0;
    endcase
  end

  // Head barrier update, saturating both ways
  always_comb begin
    if (func_r == FN_BAR_ADD) begin
      bar_new = (rd_q.bar == 8'hFF) ? rd_q.bar : rd_q.bar + 8'd1;
    end else begin
      bar_new = (rd_q.bar == 8'h00) ? rd_q.bar : rd_q.bar - 8'd1;
    end
  end

  // Write address and data select
  always_comb begin
    wr_data = rd_q;
    unique case (cmd.wr_sel)
      WR_NEW: begin
        wr_addr = pos;
        wr_data = '{st: s_r, en: e_r, tag: t_r, bar: 8'd0};
      end
      WR_SHIFT: wr_addr = k_r[IDX_W-1:0];
      WR_CLOSE: wr_addr = k_m1[IDX_W-1:0];
      default: begin
        wr_addr     = '0;
        wr_data.bar = bar_new;
      end
    endcase
  end

  // Entry memory with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Insert decision from the found entry (rd_q) and the one after it (p_r)
  always_comb begin
    if (!pvalid_r) begin
      action = ACT_INS;
    end else if (ineg_r) begin
      action = seq_before(p_r.en, e_r) ? ACT_REPL : ACT_INS;
    end else if (!seq_before(rd_q.en, p_r.st)) begin
      action = (seq_within(s_r, p_r.st, rd_q.en) && seq_before(p_r.en, e_r))
               ? ACT_REPL : ACT_DROP;
    end else if (!seq_before(rd_q.en, e_r)) begin
      action = ACT_DROP;
    end else if (!seq_before(s_r, p_r.st) && !seq_before(p_r.en, e_r)) begin
      action = ACT_DROP;
    end else begin
      action = seq_before(p_r.en, e_r) ? ACT_REPL : ACT_INS;
    end
  end

  // Status to the controller
  always_comb begin
    sts.func          = func_r;
    sts.empty         = (cnt_r == '0);
    sts.full          = (cnt_r == CNT_W'(CAPACITY));
    sts.brk           = !seq_before(s_r, rd_q.en);
    sts.idx_zero      = (idx_r == '0);
    sts.action        = action;
    sts.pos_eq_cnt    = (CNT_W'(pos) == cnt_r);
    sts.km1_eq_pos    = (k_m1 == CNT_W'(pos));
    sts.k_eq_cnt      = (k_r == cnt_r);
    sts.head_bar_zero = (rd_q.bar == 8'd0);
    sts.out_free      = !out_vld_r || out_rdy;
  end

  // Operation registers, scan index and counters
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r   <= in_func;
      s_r      <= in_start;
      e_r      <= in_end;
      t_r      <= in_tag;
      idx_r    <= IDX_W'(cnt_r - CNT_W'(1));
      ineg_r   <= (cnt_r == '0);
      pvalid_r <= 1'b0;
    end else if (cmd.scan_step) begin
      p_r      <= rd_q;
      pvalid_r <= 1'b1;
      if (idx_r == '0) begin
        ineg_r <= 1'b1;
      end else begin
        idx_r <= idx_r - IDX_W'(1);
      end
    end else if (cmd.cap_head) begin
      p_r <= rd_q;
    end
    if (cmd.wr_en && cmd.wr_sel == WR_BAR) begin
      bar_r <= bar_new;
    end
    priority if (cmd.k_shift) begin
      k_r <= cnt_r;
    end else if (cmd.k_one) begin
      k_r <= CNT_W'(1);
    end else if (cmd.k_dec) begin
      k_r <= k_m1;
    end else if (cmd.k_inc) begin
      k_r <= k_r + CNT_W'(1);
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Result fields by kind
  always_comb begin
    r_status = ST_OK;
    r_otag   = '0;
    r_ov     = 1'b0;
    r_ftag   = '0;
    r_fv     = 1'b0;
    r_bar    = '0;
    unique case (cmd.res_kind)
      RK_OK:    r_status = ST_OK;
      RK_DROP: begin
        r_status = ST_DROP;
        r_ftag   = t_r;
        r_fv     = 1'b1;
      end
      RK_REPL: begin
        r_ftag = p_r.tag;
        r_fv   = 1'b1;
      end
      RK_EMPTY: r_status = ST_EMPTY;
      RK_BLOCK: r_status = ST_BLOCK;
      RK_FULL:  r_status = ST_FULL;
      RK_TAG: begin
        r_otag = p_r.tag;
        r_ov   = 1'b1;
      end
      RK_BAR:   r_bar = bar_r;
      default:  r_status = ST_DONE;
    endcase
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_vld_r <= 1'b1;
    end else if (out_rdy) begin
      out_vld_r <= 1'b0;
    end
    if (cmd.res_load) begin
      out_r <= {5'(cnt_r), r_bar, r_fv, r_ftag, r_ov, r_otag, r_status};
    end
  end

  assign out_vld    = out_vld_r;
  assign out_fields = out_r;

endmodule

// File: hw/rtl/tcp_segment_reorder_queue_unit.sv
// ---------------------------------------------------------------------------
// tcp_segment_reorder_queue_unit
// Sorted out-of-order segment table with insert, pop, peek, barrier, clear.
// ---------------------------------------------------------------------------
// Insert scans the held entries from the tail, then shifts those after the insert
//   position up one; pop shifts the remaining entries down one.
// One item at a time; the entry memory, used for one read or one write of an entry
//   per cycle, sets the insert and pop cost.
// The next item is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) empties the table; no clearing pass.
// ---------------------------------------------------------------------------
module tcp_segment_reorder_queue_unit
  import srq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // seg_start, seg_end, seg_tag
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, out_tag, out_tag_valid, freed_tag, freed_valid, barrier_value,
  // entry_count, zero pad
  output logic [55:0] out_tdata
);

  `include "tcp_segment_reorder_queue_unit_assert.svh"

  cmd_t        cmd;
  sts_t        sts;
  logic        in_fire;
  logic [49:0] res;

  assign in_fire = in_tvalid && in_tready;

  srq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_rdy (in_tready),
    .sts    (sts),
    .cmd    (cmd)
  );

  srq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (in_tuser),
    .in_start  (in_tdata[31:0]),
    .in_end    (in_tdata[63:32]),
    .in_tag    (in_tdata[79:64]),
    .out_rdy   (out_tready),
    .out_vld   (out_tvalid),
    .out_fields(res)
  );

  assign out_tdata = {6'd0, res};

  // Checks
  `SRQ_ASSERT_NEXT(a_one_at_a_time, in_fire, !in_tready, "input taken while busy")
  `SRQ_ASSERT_IMPL(a_empty_count, out_tvalid && res[2:0] == ST_EMPTY, res[49:45] == 5'd0,
                   "empty status with nonzero count")
  `SRQ_ASSERT_IMPL(a_tag_ok, out_tvalid && res[19], res[2:0] == ST_OK,
                   "tag reported with non-ok status")

endmodule

// File: tb/tb_tcp_segment_reorder_queue_unit.sv
// ---------------------------------------------------------------------------
// Testbench for tcp_segment_reorder_queue_unit
// Drives insert, pop, peek, barrier and clear operations through the input
// stream and checks each result against a cycle-free software model of the
// sorted segment table, with random stalls on both stream sides.
// ---------------------------------------------------------------------------
class seg_table_scoreboard;
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] otag;
    logic        ovalid;
    logic [15:0] ftag;
    logic        fvalid;
    logic [7:0]  bval;
    logic [4:0]  cnt;
  } result_t;

  localparam int DEPTH = 16;
  logic [31:0] seg_lo [DEPTH+1];
  logic [31:0] seg_hi [DEPTH+1];
  logic [15:0] seg_tag [DEPTH+1];
  logic [7:0]  seg_bar [DEPTH+1];
  int          held;
  result_t     pending [$];
  int          errors;
  int          checked;
  int          status_seen [8];

  function new();
    held = 0;
    errors = 0;
    checked = 0;
  endfunction

  static function bit seq_lt(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  static function bit seq_in(logic [31:0] x, logic [31:0] lo, logic [31:0] hi);
    logic [31:0] span;
    logic [31:0] off;
    span = hi - lo;
    off = x - lo;
    return span >= off;
  endfunction

  function void put(int pos, logic [31:0] s, logic [31:0] e, logic [15:0] t);
    seg_lo[pos] = s;
    seg_hi[pos] = e;
    seg_tag[pos] = t;
    seg_bar[pos] = 8'd0;
  endfunction

  function void open_at(int pos);
    for (int k = held; k > pos; k--) begin
      seg_lo[k] = seg_lo[k-1];
      seg_hi[k] = seg_hi[k-1];
      seg_tag[k] = seg_tag[k-1];
      seg_bar[k] = seg_bar[k-1];
    end
    held++;
  endfunction

  // Apply one accepted operation and queue the result it must produce
  function void note_op(logic [2:0] fn, logic [31:0] s, logic [31:0] e, logic [15:0] t);
    result_t r;
    int i;
    int p;
    int act;
    r = '0;
    case (fn)
      srq_pkg::FN_INSERT: begin
        if (held >= DEPTH) begin
          r.status = srq_pkg::ST_FULL;
        end else if (held == 0) begin
          open_at(0);
          put(0, s, e, t);
        end else begin
          i = held - 1;
          p = -1;
          while (i >= 0 && seq_lt(s, seg_hi[i])) begin
            p = i;
            i--;
          end
          if (p < 0) act = srq_pkg::ACT_INS;
          else if (i < 0) act = seq_lt(seg_hi[p], e) ? srq_pkg::ACT_REPL : srq_pkg::ACT_INS;
          else if (!seq_lt(seg_hi[i], seg_lo[p])) begin
            act = (seq_in(s, seg_lo[p], seg_hi[i]) && seq_lt(seg_hi[p], e)) ?
                  srq_pkg::ACT_REPL : srq_pkg::ACT_DROP;
          end else if (!seq_lt(seg_hi[i], e)) act = srq_pkg::ACT_DROP;
          else if (!seq_lt(s, seg_lo[p]) && !seq_lt(seg_hi[p], e)) act = srq_pkg::ACT_DROP;
          else act = seq_lt(seg_hi[p], e) ? srq_pkg::ACT_REPL : srq_pkg::ACT_INS;
          if (act == srq_pkg::ACT_DROP) begin
            r.status = srq_pkg::ST_DROP;
            r.ftag = t;
            r.fvalid = 1'b1;
          end else if (act == srq_pkg::ACT_REPL) begin
            r.ftag = seg_tag[p];
            r.fvalid = 1'b1;
            put(p, s, e, t);
          end else begin
            open_at(i + 1);
            put(i + 1, s, e, t);
          end
        end
      end
      srq_pkg::FN_POP, srq_pkg::FN_PEEK: begin
        if (held == 0) r.status = srq_pkg::ST_EMPTY;
        else if (seg_bar[0] != 0) r.status = srq_pkg::ST_BLOCK;
        else begin
          r.otag = seg_tag[0];
          r.ovalid = 1'b1;
          if (fn == srq_pkg::FN_POP) begin
            for (int k = 1; k < held; k++) begin
              seg_lo[k-1] = seg_lo[k];
              seg_hi[k-1] = seg_hi[k];
              seg_tag[k-1] = seg_tag[k];
              seg_bar[k-1] = seg_bar[k];
            end
            held--;
          end
        end
      end
      srq_pkg::FN_BAR_ADD, srq_pkg::FN_BAR_REM: begin
        if (held == 0) r.status = srq_pkg::ST_EMPTY;
        else begin
          if (fn == srq_pkg::FN_BAR_ADD) begin
            if (seg_bar[0] != 8'hFF) seg_bar[0]++;
          end else if (seg_bar[0] != 0) seg_bar[0]--;
          r.bval = seg_bar[0];
        end
      end
      srq_pkg::FN_CLEAR: begin
        held = 0;
        r.status = srq_pkg::ST_DONE;
      end
      default: r.status = srq_pkg::ST_DONE;
    endcase
    r.cnt = held[4:0];
    status_seen[r.status]++;
    pending.push_back(r);
  endfunction

  // Compare one delivered result with the oldest expectation
  function void check_result(logic [55:0] data);
    result_t got;
    result_t exp;
    got = {data[2:0], data[18:3], data[19], data[35:20], data[36], data[44:37], data[49:45]};
    checked++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", data);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp || data[55:50] !== 6'd0) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch #%0d: status %0d/%0d otag %h/%h ov %b/%b ",
                  "ftag %h/%h fv %b/%b bar %0d/%0d cnt %0d/%0d"},
                 checked, exp.status, got.status, exp.otag, got.otag, exp.ovalid, got.ovalid,
                 exp.ftag, got.ftag, exp.fvalid, got.fvalid, exp.bval, got.bval,
                 exp.cnt, got.cnt);
    end
  endfunction
endclass

module tb_tcp_segment_reorder_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import srq_pkg::*;

  localparam int LIMIT = 4000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  seg_table_scoreboard board;
  int  cycles;
  bit  hold_off;
  bit  sending_done;
  logic [31:0] base_seq;

  tcp_segment_reorder_queue_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offer one operation and hold it until the transfer; valid stays high
  // after the transfer so the next call can follow with no gap
  task automatic send_op(logic [2:0] fn, logic [31:0] s, logic [31:0] e, logic [15:0] t);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {t, e, s};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_op(fn, s, e, t);
  endtask

  // Drop valid and wait for every expected result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  // Insert a segment near the running sequence base
  task automatic send_near(int spread);
    logic [31:0] s;
    s = base_seq + $urandom_range(0, spread);
    send_op(FN_INSERT, s, s + $urandom_range(1, 40), 16'($urandom));
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int w;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      w = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 11);
      if (w != 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_result(out_tdata);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** tcp_segment_reorder_queue_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    int r;
    board = new();
    cycles = 0;
    hold_off = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FN_CLEAR;
    rst_n = 1'b0;
    base_seq = 32'hFFFF_FF00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table cases, extremes, wrap of the sequence space
    send_op(FN_POP, '0, '0, '0);
    send_op(FN_PEEK, '0, '0, '0);
    send_op(FN_BAR_ADD, '0, '0, '0);
    send_op(FN_BAR_REM, '0, '0, '0);
    send_op(FN_INSERT, 32'hFFFF_FFF0, 32'h0000_0010, 16'hFFFF);
    send_op(FN_INSERT, 32'h0000_0010, 32'h0000_0020, 16'h0001);
    send_op(FN_INSERT, 32'h0000_0000, 32'h0000_0008, 16'h0002);
    send_op(FN_INSERT, 32'h0000_0008, 32'h0000_0030, 16'h0003);
    send_op(FN_INSERT, 32'hFFFF_FFE0, 32'hFFFF_FFF8, 16'h0004);
    send_op(FN_INSERT, 32'hFFFF_FFD0, 32'h0000_0040, 16'h0000);
    send_op(FN_INSERT, 32'h0000_0100, 32'h0000_0200, 16'hA5A5);
    send_op(FN_INSERT, 32'h0000_0120, 32'h0000_0180, 16'h5A5A);
    send_op(FN_BAR_REM, '0, '0, '0);
    send_op(FN_BAR_ADD, '0, '0, '0);
    send_op(FN_PEEK, '0, '0, '0);
    send_op(FN_POP, '0, '0, '0);
    send_op(FN_BAR_REM, '0, '0, '0);
    send_op(FN_POP, '0, '0, '0);
    send_op(3'd6, 32'hFFFF_FFFF, '0, '0);
    send_op(3'd7, '0, 32'hFFFF_FFFF, '0);
    for (int k = 0; k < 18; k++) send_op(FN_INSERT, 32'(k * 64), 32'(k * 64 + 32), 16'(k));
    for (int k = 0; k < 256; k++) send_op(FN_BAR_ADD, '0, '0, '0);
    send_op(FN_PEEK, '0, '0, '0);
    send_op(FN_CLEAR, '0, '0, '0);

    // Random: mostly inserts clustered near a moving base, some raw noise
    for (int n = 0; n < 1650; n++) begin
      if (n == 500) hold_off = 1'b1;
      if (n == 1000) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 50) send_near($urandom_range(0, 1) ? 60 : 300);
      else if (r < 55) send_op(FN_INSERT, $urandom, $urandom, 16'($urandom));
      else if (r < 73) begin
        send_op(FN_POP, $urandom, $urandom, 16'($urandom));
        base_seq = base_seq + $urandom_range(0, 30);
      end else if (r < 80) send_op(FN_PEEK, '0, '0, '0);
      else if (r < 87) send_op(FN_BAR_ADD, '0, '0, '0);
      else if (r < 95) send_op(FN_BAR_REM, '0, '0, '0);
      else if (r < 98) send_op(FN_CLEAR, '0, '0, '0);
      else send_op(3'($urandom_range(6, 7)), $urandom, $urandom, 16'($urandom));
    end

    wait_drained();
    repeat (100) @(posedge clk);
    $display("covered %0d results: ok %0d drop %0d empty %0d block %0d full %0d done %0d",
             board.checked, board.status_seen[ST_OK], board.status_seen[ST_DROP],
             board.status_seen[ST_EMPTY], board.status_seen[ST_BLOCK],
             board.status_seen[ST_FULL], board.status_seen[ST_DONE]);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("** tcp_segment_reorder_queue_unit: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.pending.size());
      $display("** tcp_segment_reorder_queue_unit: FAILED **");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/srq_pkg.sv
hw/rtl/srq_ctrl.sv
hw/rtl/srq_dp.sv
hw/rtl/tcp_segment_reorder_queue_unit.sv
tb/tb_tcp_segment_reorder_queue_unit.sv
